// ===== sv/pvdd_pkg.sv =====
// ----------------------------------------------------------------------------
// pvdd_pkg
// Shared types and constants of the postings varint delta decoder.
// ----------------------------------------------------------------------------
package pvdd_pkg;

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_DELTA = 3'd1,
        PH_SCORE = 3'd2,
        PH_LEN   = 3'd3,
        PH_ID    = 3'd4,
        PH_IDLE  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_ID     = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 96;
    localparam int unsigned OUT_USER_W = 2;

    localparam logic [7:0] VARINT_CONT = 8'h80;
    localparam logic [7:0] VARINT_MASK = 8'h7F;

endpackage

// ===== sv/postings_varint_delta_decoder.sv =====
// ----------------------------------------------------------------------------
// postings_varint_delta_decoder
// Byte-wise parser of a postings buffer: count, LEB128 deltas into a running
// document hash, raw score, id length and id bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one buffer byte per transaction in s_axis_tdata, with
//   s_axis_tlast on the buffer's final byte.
//   Master stream: at most one result per input byte. m_axis_tuser carries
//   the kind (header, id byte, end report), m_axis_tlast the id_last flag.
//   A byte is taken into the input register, then parsed, and its result
//   is written to the result register, from which it leaves.
//   Throughput: one byte per cycle unless a stalled receiver holds the
//   result register; the parse state updates from the input register.
//   A stalled receiver holds the result register; the byte in the input
//   register waits there and the slave side stalls until the result is taken.
//   Reset (synchronous, active low) empties both registers and returns the
//   parser to the count header. After the final byte of a buffer the parser
//   returns to the same state on its own.
// ----------------------------------------------------------------------------
module postings_varint_delta_decoder
    import pvdd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tlast,   // buffer_end
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] doc_hash, [63:32] score_bits, [79:64] id_length,
    // [87:80] id_byte, [88] buffer_done, [89] end_status, [95:90] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // [1:0] kind
    output logic                  m_axis_tlast    // id_last
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;

    t_phase      r_phase,         n_phase;
    logic [31:0] r_postings_left, n_postings_left;
    logic [2:0]  r_byte_index,    n_byte_index;
    logic [31:0] r_delta_acc,     n_delta_acc;
    logic [31:0] r_running_hash,  n_running_hash;
    logic [31:0] r_score_acc,     n_score_acc;
    logic [15:0] r_id_len,        n_id_len;
    logic [15:0] r_id_left,       n_id_left;

    logic        r_out_valid;
    t_kind       r_out_kind,      n_out_kind;
    logic [31:0] r_out_hash;
    logic [31:0] r_out_score;
    logic [15:0] r_out_len;
    logic [7:0]  r_out_id_byte,   n_out_id_byte;
    logic        r_out_last,      n_out_last;
    logic        r_out_done;
    logic        r_out_status,    n_out_status;

    logic        n_emit;
    logic        w_adv;
    logic [1:0]  w_bi;
    logic [2:0]  w_di;
    logic [31:0] w_delta_part;
    logic [31:0] w_lane;
    logic [31:0] w_left_dec;
    logic [15:0] w_id_dec;
    logic        w_clean;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    assign w_bi       = r_byte_index[1:0];
    assign w_di       = (r_byte_index > 3'd4) ? 3'd4 : r_byte_index;
    assign w_lane     = {24'd0, r_in_byte} << {w_bi, 3'b000};
    assign w_left_dec = r_postings_left - 32'd1;
    assign w_id_dec   = r_id_left - 16'd1;

    always_comb begin
        unique case (w_di)
            3'd0:    w_delta_part = {25'd0, r_in_byte[6:0] & VARINT_MASK[6:0]};
            3'd1:    w_delta_part = {18'd0, r_in_byte[6:0] & VARINT_MASK[6:0], 7'd0};
            3'd2:    w_delta_part = {11'd0, r_in_byte[6:0] & VARINT_MASK[6:0], 14'd0};
            3'd3:    w_delta_part = {4'd0, r_in_byte[6:0] & VARINT_MASK[6:0], 21'd0};
            default: w_delta_part = {r_in_byte[3:0] & VARINT_MASK[3:0], 28'd0};
        endcase
    end

    always_comb begin
        n_phase         = r_phase;
        n_postings_left = r_postings_left;
        n_byte_index    = r_byte_index;
        n_delta_acc     = r_delta_acc;
        n_running_hash  = r_running_hash;
        n_score_acc     = r_score_acc;
        n_id_len        = r_id_len;
        n_id_left       = r_id_left;
        unique case (r_phase)
            PH_COUNT: begin
                n_postings_left = r_postings_left | w_lane;
                n_byte_index    = {1'b0, w_bi} + 3'd1;
                if (w_bi == 2'd3) begin
                    n_byte_index = 3'd0;
                    n_phase      = (n_postings_left != 32'd0) ? PH_DELTA : PH_IDLE;
                end
            end
            PH_DELTA: begin
                n_delta_acc  = r_delta_acc | w_delta_part;
                n_byte_index = w_di + 3'd1;
                if (((r_in_byte & VARINT_CONT) == 8'd0) || (w_di == 3'd4)) begin
                    n_running_hash = r_running_hash + n_delta_acc;
                    n_delta_acc    = 32'd0;
                    n_score_acc    = 32'd0;
                    n_id_len       = 16'd0;
                    n_byte_index   = 3'd0;
                    n_phase        = PH_SCORE;
                end
            end
            PH_SCORE: begin
                n_score_acc  = r_score_acc | w_lane;
                n_byte_index = {1'b0, w_bi} + 3'd1;
                if (w_bi == 2'd3) begin
                    n_byte_index = 3'd0;
                    n_phase      = PH_LEN;
                end
            end
            PH_LEN: begin
                n_id_len     = r_id_len | (w_bi[0] ? {r_in_byte, 8'd0} : {8'd0, r_in_byte});
                n_byte_index = {2'b00, w_bi[0]} + 3'd1;
                if (w_bi[0]) begin
                    n_id_left    = n_id_len;
                    n_byte_index = 3'd0;
                    if (n_id_len == 16'd0) begin
                        n_postings_left = w_left_dec;
                        n_phase         = (w_left_dec != 32'd0) ? PH_DELTA : PH_IDLE;
                    end else begin
                        n_phase = PH_ID;
                    end
                end
            end
            PH_ID: begin
                n_id_left = w_id_dec;
                if (w_id_dec == 16'd0) begin
                    n_postings_left = w_left_dec;
                    n_byte_index    = 3'd0;
                    n_phase         = (w_left_dec != 32'd0) ? PH_DELTA : PH_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_emit        = 1'b0;
        n_out_kind    = KIND_HEADER;
        n_out_id_byte = 8'd0;
        n_out_last    = 1'b0;
        unique case (r_phase)
            PH_LEN: begin
                if (w_bi[0]) begin
                    n_emit     = 1'b1;
                    n_out_last = (n_id_len == 16'd0);
                end
            end
            PH_ID: begin
                n_emit        = 1'b1;
                n_out_kind    = KIND_ID;
                n_out_id_byte = r_in_byte;
                n_out_last    = (w_id_dec == 16'd0);
            end
            default: begin
            end
        endcase
    end

    assign w_clean      = (n_phase == PH_IDLE) ||
                          ((n_phase == PH_DELTA) && (n_byte_index == 3'd0));
    assign n_out_status = r_in_end && !w_clean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_adv && r_in_end)) begin
            r_phase         <= PH_COUNT;
            r_postings_left <= 32'd0;
            r_byte_index    <= 3'd0;
            r_delta_acc     <= 32'd0;
            r_running_hash  <= 32'd0;
            r_score_acc     <= 32'd0;
            r_id_len        <= 16'd0;
            r_id_left       <= 16'd0;
        end else if (w_adv) begin
            r_phase         <= n_phase;
            r_postings_left <= n_postings_left;
            r_byte_index    <= n_byte_index;
            r_delta_acc     <= n_delta_acc;
            r_running_hash  <= n_running_hash;
            r_score_acc     <= n_score_acc;
            r_id_len        <= n_id_len;
            r_id_left       <= n_id_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && (n_emit || r_in_end)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && (n_emit || r_in_end)) begin
            r_out_kind    <= n_emit ? n_out_kind : KIND_END;
            r_out_hash    <= n_emit ? n_running_hash : 32'd0;
            r_out_score   <= n_emit ? n_score_acc : 32'd0;
            r_out_len     <= n_emit ? n_id_len : 16'd0;
            r_out_id_byte <= n_out_id_byte;
            r_out_last    <= n_out_last;
            r_out_done    <= r_in_end;
            r_out_status  <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {6'd0, r_out_status, r_out_done, r_out_id_byte,
                            r_out_len, r_out_score, r_out_hash};

endmodule
